@@ hw/rtl/tkct_pkg.sv @@
// Package for the top-k count tracker: widths, beat types, cell control and states.
`default_nettype none

package tkct_pkg;

    localparam int unsigned ENTRIES = 8;
    localparam int unsigned RESULT_LIMIT = 8;
    localparam int unsigned TAG_W = 32;
    localparam int unsigned COUNT_W = 31;
    localparam int unsigned RANK_W = 3;
    localparam int unsigned LEN_W = 4;

    typedef struct packed {
        logic               func;
        logic [TAG_W-1:0]   item_value;
        logic [COUNT_W-1:0] item_count;
    } tkct_in_t;

    typedef struct packed {
        logic [TAG_W-1:0]   out_value;
        logic [COUNT_W-1:0] out_count;
        logic [RANK_W-1:0]  out_rank;
        logic               list_empty;
        logic               last;
    } tkct_out_t;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_DUMP = 1'b1
    } tkct_func_t;

    typedef struct packed {
        logic push;
        logic clr_inactive;
        logic shift;
    } tkct_cell_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_DUMP
    } tkct_state_t;

    localparam int unsigned LIM_A = (ENTRIES < RESULT_LIMIT) ? ENTRIES : RESULT_LIMIT;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LIM_A);

    function automatic logic [LEN_W-1:0] active_len(input logic [LEN_W-1:0] top_count);
        logic [LEN_W-1:0] k;
        k = top_count;
        if (k == '0) begin
            k = LEN_W'(1);
        end
        if (k > LEN_MAX) begin
            k = LEN_MAX;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tkct_cell.sv @@
// One list cell: holds a tag and a count, inserts, shifts down on push and up on read-out.
`default_nettype none

module tkct_cell
    import tkct_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire tkct_cell_ctl_t     ctl,
    input  wire logic               active,
    input  wire logic [TAG_W-1:0]   new_tag,
    input  wire logic [COUNT_W-1:0] new_count,
    input  wire logic               hit_in,
    input  wire logic [TAG_W-1:0]   prev_tag,
    input  wire logic [COUNT_W-1:0] prev_count,
    input  wire logic [TAG_W-1:0]   next_tag,
    input  wire logic [COUNT_W-1:0] next_count,
    output logic                    hit_out,
    output logic [TAG_W-1:0]        tag,
    output logic [COUNT_W-1:0]      count
);

    logic [TAG_W-1:0]   tag_reg;
    logic [TAG_W-1:0]   tag_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               gt;

    assign gt      = new_count > count_reg;
    assign hit_out = hit_in | (gt & active);
    assign tag     = tag_reg;
    assign count   = count_reg;

    always_comb begin
        tag_next   = tag_reg;
        count_next = count_reg;
        if (ctl.push && active) begin
            if (hit_in) begin
                tag_next   = prev_tag;
                count_next = prev_count;
            end else if (gt) begin
                tag_next   = new_tag;
                count_next = new_count;
            end
        end else if (ctl.clr_inactive && !active) begin
            count_next = '0;
        end else if (ctl.shift) begin
            tag_next   = next_tag;
            count_next = next_count;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg <= tag_next;
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/top_k_count_tracker.sv @@
// Top level of the top-k count tracker: cell chain, read-out sequencer and output register.
//
// Input beats arrive on s_valid/s_ready with an tkct_in_t payload. A push beat
// (func 0) is inserted into the sorted chain of cells in the cycle it is
// accepted, so pushes are taken at one beat per cycle while the block is idle.
// An end-of-group beat (func 1) starts a read-out: the chain shifts towards
// cell 0 once per cycle, and every nonzero entry is sent as one result beat
// on m_valid/m_ready, with last set on the final one, or a single beat with
// list_empty set when nothing was held. The read-out steps through at most the active
// cells, that is top_count cells with zero taken as one and values above eight taken
// as eight, and it ends early after the last nonzero entry. After the end-of-group
// beat is accepted, the state register enters the read-out and the first result is
// then loaded into the output register. The input is not ready during the read-out.
// A single output register holds the pending result; when the receiver stalls, the
// chain stops shifting until the register is free. Pushes are still accepted while a
// finished result waits in the register. After reset all counts are zero, top_count
// is 1 and no result is pending. cfg_we writes top_count from cfg_wdata at once; the
// user must write it only while the block is idle, which the block does not enforce.
`default_nettype none

module top_k_count_tracker
    import tkct_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [LEN_W-1:0] cfg_wdata,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire tkct_in_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output tkct_out_t             m_data
);

    logic [LEN_W-1:0]  top_count_reg;
    tkct_state_t       state_reg;
    tkct_state_t       state_next;
    logic [RANK_W-1:0] step_reg;
    logic [RANK_W-1:0] step_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    tkct_out_t         m_data_reg;
    tkct_out_t         m_data_next;

    logic [LEN_W-1:0]   len;
    logic               in_accept;
    logic               adv;
    logic               emit;
    logic               final_step;
    logic               rest_nz;
    tkct_cell_ctl_t     ctl;

    logic [TAG_W-1:0]   tags [ENTRIES];
    logic [COUNT_W-1:0] counts [ENTRIES];
    logic [ENTRIES:0]   hits;
    logic [ENTRIES-1:0] nz;

    assign len        = active_len(top_count_reg);
    assign s_ready    = (state_reg == ST_IDLE);
    assign in_accept  = s_valid && s_ready;
    assign hits[0]    = 1'b0;
    assign adv        = !m_valid_reg || m_ready;
    assign final_step = ({1'b0, step_reg} == (len - LEN_W'(1)));
    assign rest_nz    = |nz[ENTRIES-1:1];
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    generate
        for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
            logic [TAG_W-1:0]   p_tag;
            logic [COUNT_W-1:0] p_count;
            logic [TAG_W-1:0]   n_tag;
            logic [COUNT_W-1:0] n_count;

            if (i == 0) begin : g_first
                assign p_tag   = '0;
                assign p_count = '0;
            end else begin : g_mid
                assign p_tag   = tags[i-1];
                assign p_count = counts[i-1];
            end
            if (i == ENTRIES - 1) begin : g_end
                assign n_tag   = '0;
                assign n_count = '0;
            end else begin : g_body
                assign n_tag   = tags[i+1];
                assign n_count = counts[i+1];
            end

            assign nz[i] = (counts[i] != '0);

            tkct_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .active     (32'(i) < 32'(len)),
                .new_tag    (s_data.item_value),
                .new_count  (s_data.item_count),
                .hit_in     (hits[i]),
                .prev_tag   (p_tag),
                .prev_count (p_count),
                .next_tag   (n_tag),
                .next_count (n_count),
                .hit_out    (hits[i+1]),
                .tag        (tags[i]),
                .count      (counts[i])
            );
        end
    endgenerate

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ctl          = '0;
        emit         = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_data.func == FUNC_PUSH) begin
                        ctl.push = 1'b1;
                    end else begin
                        ctl.clr_inactive = 1'b1;
                        step_next        = '0;
                        state_next       = ST_DUMP;
                    end
                end
            end
            ST_DUMP: begin
                if (adv) begin
                    ctl.shift = 1'b1;
                    step_next = step_reg + RANK_W'(1);
                    if (nz[0]) begin
                        emit                   = 1'b1;
                        m_data_next.out_value  = tags[0];
                        m_data_next.out_count  = counts[0];
                        m_data_next.out_rank   = step_reg;
                        m_data_next.list_empty = 1'b0;
                        m_data_next.last       = !rest_nz;
                    end else if (final_step) begin
                        emit                   = 1'b1;
                        m_data_next            = '0;
                        m_data_next.list_empty = 1'b1;
                        m_data_next.last       = 1'b1;
                    end
                    if (final_step || (nz[0] && !rest_nz)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        step_reg   <= step_next;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            top_count_reg <= LEN_W'(1);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                top_count_reg <= cfg_wdata;
            end
        end
    end

`ifndef SYNTHESIS
    // A result is only produced when the output register is free or being drained.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!m_valid_reg || m_ready))
        else $error("result produced over a pending beat");

    // Once a read-out finishes, every count in the chain is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP && state_next == ST_IDLE) |=> (nz == '0))
        else $error("counts not cleared after read-out");

    // The input is never taken during a read-out.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DUMP) |-> !in_accept)
        else $error("input accepted during read-out");
`endif

endmodule

`default_nettype wire

@@ tb/top_k_count_tracker_test.sv @@
// Self-checking testbench for the top-k count tracker: a directed table, then random groups.
module top_k_count_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tkct_pkg::*;

    typedef enum logic {
        ROW_CFG,
        ROW_BEAT
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        logic [LEN_W-1:0] top;
        tkct_in_t         beat;
        logic             typed;
        tkct_out_t        reply;
    } script_row_t;

    localparam tkct_out_t EMPTY_REPORT = '{32'h0, 31'h0, 3'd0, 1'b1, 1'b1};
    localparam tkct_out_t FULL_SCALE_REPORT = '{32'hFFFF_FFFF, 31'h7FFF_FFFF, 3'd0, 1'b0, 1'b1};
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASES = 6;
    localparam int BEATS_PER_PHASE = 31;

    localparam script_row_t SCRIPT [30] = '{
        '{ROW_BEAT, 4'd0, '{FUNC_DUMP, 32'hAAAA_5555, 31'h2AAA_5555}, 1'b1, EMPTY_REPORT},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'hFFFF_FFFF, 31'h7FFF_FFFF}, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_DUMP, 32'h5555_AAAA, 31'h5555_2AAA}, 1'b1, FULL_SCALE_REPORT},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'h0000_0000, 31'h0}, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_DUMP, 32'h0000_0000, 31'h0}, 1'b1, EMPTY_REPORT},
        '{ROW_CFG, 4'd8, '0, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'h10, 31'd5}, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'h11, 31'd5}, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'h12, 31'd9}, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'h13, 31'd1}, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'h14, 31'd0}, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'h15, 31'd7}, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_DUMP, 32'h0, 31'h0}, 1'b0, '0},
        '{ROW_CFG, 4'd4, '0, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'h20, 31'd4}, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'h21, 31'd3}, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'h22, 31'd2}, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'h23, 31'd1}, 1'b0, '0},
        '{ROW_CFG, 4'd2, '0, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'h24, 31'd10}, 1'b0, '0},
        '{ROW_CFG, 4'd4, '0, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_DUMP, 32'h0, 31'h0}, 1'b0, '0},
        '{ROW_CFG, 4'd0, '0, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'h30, 31'd2}, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'h31, 31'd3}, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_DUMP, 32'h0, 31'h0}, 1'b0, '0},
        '{ROW_CFG, 4'd15, '0, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'h41, 31'd3}, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_PUSH, 32'h42, 31'd6}, 1'b0, '0},
        '{ROW_BEAT, 4'd0, '{FUNC_DUMP, 32'h0, 31'h0}, 1'b0, '0}
    };

    localparam logic [LEN_W-1:0] PHASE_TOP [PHASES] = '{4'd8, 4'd1, 4'd5, 4'd15, 4'd8, 4'd3};
    localparam int PHASE_SEND_IDLE [PHASES] = '{0, 67, 0, 32, 0, 32};
    localparam int PHASE_RECV_STALL [PHASES] = '{0, 0, 67, 32, 0, 32};
    localparam int PRESSURE_PHASE = 4;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_we = 1'b0;
    logic [LEN_W-1:0] cfg_wdata = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    tkct_in_t         s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    tkct_out_t        m_data;

    logic [LEN_W-1:0]   model_top = LEN_W'(1);
    logic [TAG_W-1:0]   model_tags [ENTRIES];
    logic [COUNT_W-1:0] model_counts [ENTRIES];
    tkct_out_t          report_run [$];
    tkct_out_t          ranks_owed [$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic pressure_armed = 1'b0;
    int  beats_sent = 0;
    int  directed_beats = 0;
    int  reports_sent = 0;
    int  results_seen = 0;
    int  top_writes = 0;
    int  fail_count = 0;

    top_k_count_tracker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    function automatic int kept_length();
        int k;
        k = int'(model_top);
        if (k == 0) begin
            k = 1;
        end
        if (k > int'(ENTRIES)) begin
            k = int'(ENTRIES);
        end
        if (k > int'(RESULT_LIMIT)) begin
            k = int'(RESULT_LIMIT);
        end
        return k;
    endfunction

    task automatic ranking_update(input tkct_in_t beat);
        int kept;
        int pos;
        int j;
        tkct_out_t entry;
        kept = kept_length();
        report_run.delete();
        if (tkct_func_t'(beat.func) == FUNC_PUSH) begin
            for (pos = 0; pos < kept; pos++) begin
                if (beat.item_count > model_counts[pos]) begin
                    for (j = kept - 1; j > pos; j--) begin
                        model_tags[j] = model_tags[j - 1];
                        model_counts[j] = model_counts[j - 1];
                    end
                    model_tags[pos] = beat.item_value;
                    model_counts[pos] = beat.item_count;
                    break;
                end
            end
        end else begin
            for (pos = 0; pos < kept; pos++) begin
                if (model_counts[pos] != '0) begin
                    entry = '{model_tags[pos], model_counts[pos], RANK_W'(pos), 1'b0, 1'b0};
                    report_run.push_back(entry);
                end
            end
            if (report_run.size() == 0) begin
                report_run.push_back(EMPTY_REPORT);
            end else begin
                report_run[report_run.size() - 1].last = 1'b1;
            end
            for (pos = 0; pos < int'(ENTRIES); pos++) begin
                model_counts[pos] = '0;
            end
        end
    endtask

    task automatic send_beat(input tkct_in_t beat, input logic typed, input tkct_out_t reply);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= beat;
        do @(posedge aclk); while (!s_ready);
        ranking_update(beat);
        if (typed) begin
            ranks_owed.push_back(reply);
        end else begin
            foreach (report_run[i]) begin
                ranks_owed.push_back(report_run[i]);
            end
        end
        if (tkct_func_t'(beat.func) == FUNC_DUMP) begin
            reports_sent++;
        end
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic write_top(input logic [LEN_W-1:0] value);
        s_valid <= 1'b0;
        while (ranks_owed.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        model_top = value;
        top_writes++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        tkct_in_t beat;
        int phase;
        int phase_end;
        int pushes;
        int r;
        for (r = 0; r < int'(ENTRIES); r++) begin
            model_tags[r] = '0;
            model_counts[r] = '0;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (r = 0; r < $size(SCRIPT); r++) begin
            if (SCRIPT[r].kind == ROW_CFG) begin
                write_top(SCRIPT[r].top);
            end else begin
                send_beat(SCRIPT[r].beat, SCRIPT[r].typed, SCRIPT[r].reply);
                directed_beats++;
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            write_top(PHASE_TOP[phase]);
            send_idle_pct = PHASE_SEND_IDLE[phase];
            recv_stall_pct = PHASE_RECV_STALL[phase];
            if (phase == PRESSURE_PHASE) begin
                pressure_armed = 1'b1;
            end
            phase_end = beats_sent + BEATS_PER_PHASE;
            while (beats_sent < phase_end) begin
                pushes = $urandom_range(0, 12);
                repeat (pushes) begin
                    beat.func = FUNC_PUSH;
                    case ($urandom_range(0, 9))
                        0: beat.item_value = '0;
                        1: beat.item_value = '1;
                        default: beat.item_value = $urandom();
                    endcase
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: beat.item_count = COUNT_W'($urandom_range(0, 12));
                        6, 7: beat.item_count = COUNT_W'($urandom());
                        8: beat.item_count = '1;
                        default: beat.item_count = COUNT_W'(1);
                    endcase
                    send_beat(beat, 1'b0, '0);
                end
                beat.func = FUNC_DUMP;
                beat.item_value = $urandom();
                beat.item_count = COUNT_W'($urandom());
                send_beat(beat, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        while (ranks_owed.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);

        $display("Sent %0d input beats (%0d from the directed table), %0d of them end-of-group.",
                 beats_sent, directed_beats, reports_sent);
        $display("Checked %0d result beats over %0d top_count writes; %0d mismatches.",
                 results_seen, top_writes, fail_count);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (pressure_armed && m_valid) begin
                pressure_armed = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : monitor
        tkct_out_t due;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (ranks_owed.size() == 0) begin
                $error("Result beat with nothing outstanding: %p", m_data);
                fail_count++;
            end else begin
                due = ranks_owed.pop_front();
                if (m_data.out_value !== due.out_value) begin
                    $error("out_value: expected %h, got %h", due.out_value, m_data.out_value);
                    fail_count++;
                end
                if (m_data.out_count !== due.out_count) begin
                    $error("out_count: expected %h, got %h", due.out_count, m_data.out_count);
                    fail_count++;
                end
                if (m_data.out_rank !== due.out_rank) begin
                    $error("out_rank: expected %0d, got %0d", due.out_rank, m_data.out_rank);
                    fail_count++;
                end
                if (m_data.list_empty !== due.list_empty) begin
                    $error("list_empty: expected %b, got %b", due.list_empty, m_data.list_empty);
                    fail_count++;
                end
                if (m_data.last !== due.last) begin
                    $error("last: expected %b, got %b", due.last, m_data.last);
                    fail_count++;
                end
            end
        end
    end

endmodule
